/* src/sha256_pkg.sv */
// Shared types, constants and round functions for the SHA-256 engine.
`default_nettype none

package sha256_pkg;

  // One input item as it travels from the front end to the core.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } item_t;

  // Write side of the item queue.
  typedef struct packed {
    logic  push;
    item_t item;
  } qwr_t;

  // Read side of the item queue.
  typedef struct packed {
    logic  valid;
    item_t item;
  } qrd_t;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

/* src/sha256_hash_engine_unit.sv */
// Timing: the core takes one byte per cycle while it is not compressing and the queue
// holds items; every full block then costs 64 rounds of the single round unit plus the
// chaining add. From the end mark to the first digest word come the padding bytes (a 0x80 at
// byte 56 or later spills the length into an extra block) and one or two block
// compressions; then eight words, one per cycle while not stalled.
// A four-item queue lets input continue during compression.
// Reset (synchronous, rst_n low) loads the initial hash values and empties all counts.
`default_nettype none

module sha256_hash_engine_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [7:0]   in_data_byte,
  input  wire logic         in_has_byte,
  input  wire logic         in_end_of_message,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [31:0]       out_digest_word,
  output logic [2:0]        out_word_index,
  output logic              out_last_word
);

  sha256_pkg::qwr_t q_wr;
  sha256_pkg::qrd_t q_rd;
  logic             q_full;
  logic             q_pop;

  sha256_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .q_full            (q_full),
    .q_wr              (q_wr)
  );

  sha256_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  sha256_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_rd            (q_rd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule

`default_nettype wire

/* src/sha256_front.sv */
// Input stage: registers each item and drops items that carry neither byte nor end.
`default_nettype none

module sha256_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_has_byte,
  input  wire logic              in_end_of_message,
  input  wire logic              q_full,
  output sha256_pkg::qwr_t       q_wr
);

  logic              hold_valid_r;
  sha256_pkg::item_t hold_item_r;
  logic              take;
  logic              push;

  assign push     = hold_valid_r && !q_full;
  assign in_stall = hold_valid_r && q_full;
  assign take     = in_valid && !in_stall;

  assign q_wr.push = push;
  assign q_wr.item = hold_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (take) begin
      // an empty item changes nothing downstream
      hold_valid_r <= in_has_byte || in_end_of_message;
    end else if (push) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_item_r.data_byte      <= in_data_byte;
      hold_item_r.has_byte       <= in_has_byte;
      hold_item_r.end_of_message <= in_end_of_message;
    end
  end

endmodule

`default_nettype wire

/* src/sha256_fifo.sv */
// Short item queue between the front end and the hash core.
`default_nettype none

module sha256_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sha256_pkg::qwr_t  q_wr,
  output logic                   q_full,
  output sha256_pkg::qrd_t       q_rd,
  input  wire logic              q_pop
);

  sha256_pkg::item_t            mem_r [sha256_pkg::QDepth];
  logic [sha256_pkg::QAw-1:0]   wr_ptr_r;
  logic [sha256_pkg::QAw-1:0]   rd_ptr_r;
  logic [sha256_pkg::QAw:0]     count_r;
  logic                         do_push;
  logic                         do_pop;

  assign q_full     = count_r == (sha256_pkg::QAw+1)'(sha256_pkg::QDepth);
  assign q_rd.valid = count_r != '0;
  assign q_rd.item  = mem_r[rd_ptr_r];

  assign do_push = q_wr.push && !q_full;
  assign do_pop  = q_pop && q_rd.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= q_wr.item;
  end

endmodule

`default_nettype wire

/* src/sha256_core.sv */
// Hash core: block assembly, padding, 64-round compression and digest output.
`default_nettype none

module sha256_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sha256_pkg::qrd_t  q_rd,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [31:0]            out_digest_word,
  output logic [2:0]             out_word_index,
  output logic                   out_last_word
);

  typedef enum logic [2:0] {ST_RUN, ST_COMP, ST_ADD, ST_PAD, ST_OUT} state_t;

  state_t       state_r;
  logic [31:0]  chain_r [8];
  logic [31:0]  v_r [8];
  logic [31:0]  w_r [16];    // message schedule window, w_r[0] is the current round word
  logic [23:0]  acc_r;       // bytes of the word being assembled
  logic [5:0]   fill_r;
  logic [60:0]  cnt_r;
  logic [5:0]   rnd_r;
  logic         pad_r;       // padding in progress
  logic         mark_r;      // 0x80 already pushed
  logic         len_r;       // length bytes being pushed
  logic         fin_r;       // block under compression is the last one
  logic         out_valid_r;
  logic [2:0]   out_idx_r;

  logic         push_en;
  logic [7:0]   push_val;
  logic         blk_full;
  logic [63:0]  len_bits;
  logic [7:0]   len_byte;
  logic [31:0]  t1;
  logic [31:0]  t2;
  logic [31:0]  w_new;
  logic         len_now;

  assign len_bits = {cnt_r, 3'b000};
  // length byte i sits at fill 56+i, most significant first
  assign len_byte = len_bits[{~fill_r[2:0], 3'b000} +: 8];
  assign len_now  = mark_r && (len_r || fill_r == 6'd56);

  always_comb begin
    push_en  = 1'b0;
    push_val = '0;
    q_pop    = 1'b0;
    case (state_r)
      ST_RUN: begin
        if (q_rd.valid) begin
          q_pop    = 1'b1;
          push_en  = q_rd.item.has_byte;
          push_val = q_rd.item.data_byte;
        end
      end
      ST_PAD: begin
        push_en = 1'b1;
        if (!mark_r) begin
          push_val = sha256_pkg::PAD_MARK;
        end else if (len_now) begin
          push_val = len_byte;
        end else begin
          push_val = '0;
        end
      end
      default: begin
        push_en = 1'b0;
      end
    endcase
  end

  assign blk_full = push_en && fill_r == 6'd63;

  assign t1 = v_r[7] + sha256_pkg::big_sig1(v_r[4])
            + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + sha256_pkg::ROUND_K[rnd_r] + w_r[0];
  assign t2 = sha256_pkg::big_sig0(v_r[0])
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign w_new = sha256_pkg::small_sig1(w_r[14]) + w_r[9]
               + sha256_pkg::small_sig0(w_r[1]) + w_r[0];

  assign out_valid       = out_valid_r;
  assign out_digest_word = chain_r[out_idx_r];
  assign out_word_index  = out_idx_r;
  assign out_last_word   = out_idx_r == 3'd7;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      chain_r     <= sha256_pkg::INIT_H;
      fill_r      <= '0;
      cnt_r       <= '0;
      rnd_r       <= '0;
      pad_r       <= 1'b0;
      mark_r      <= 1'b0;
      len_r       <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_idx_r   <= '0;
    end else begin
      if (push_en) begin
        fill_r <= fill_r + 6'd1;
        if (fill_r[1:0] == 2'd3) begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= {acc_r, push_val};
        end else begin
          acc_r <= {acc_r[15:0], push_val};
        end
      end
      case (state_r)
        ST_RUN: begin
          if (q_rd.valid) begin
            if (q_rd.item.has_byte) cnt_r <= cnt_r + 61'd1;
            if (q_rd.item.end_of_message) begin
              pad_r  <= 1'b1;
              mark_r <= 1'b0;
              len_r  <= 1'b0;
            end
            if (blk_full) begin
              state_r <= ST_COMP;
              v_r     <= chain_r;
              rnd_r   <= '0;
            end else if (q_rd.item.end_of_message) begin
              state_r <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          mark_r <= 1'b1;
          if (len_now) len_r <= 1'b1;
          if (blk_full) begin
            state_r <= ST_COMP;
            v_r     <= chain_r;
            rnd_r   <= '0;
            fin_r   <= len_now;
          end
        end
        ST_COMP: begin
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= w_new;
          rnd_r   <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) state_r <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + v_r[i];
          if (fin_r) begin
            state_r     <= ST_OUT;
            out_valid_r <= 1'b1;
            out_idx_r   <= '0;
          end else if (pad_r) begin
            state_r <= ST_PAD;
          end else begin
            state_r <= ST_RUN;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            if (out_idx_r == 3'd7) begin
              chain_r     <= sha256_pkg::INIT_H;
              cnt_r       <= '0;
              pad_r       <= 1'b0;
              mark_r      <= 1'b0;
              len_r       <= 1'b0;
              fin_r       <= 1'b0;
              out_valid_r <= 1'b0;
              out_idx_r   <= '0;
              state_r     <= ST_RUN;
            end else begin
              out_idx_r <= out_idx_r + 3'd1;
            end
          end
        end
        default: begin
          state_r <= ST_RUN;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
